FILE: hdl/assert_macros.svh
// Assertion macros for the router top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ant.
`define ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ant.
`define ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/czar_pkg.sv
// Types, constants and helper functions of the clock zone grid router
`default_nettype none
package czar_pkg;

  localparam int unsigned MaxXDef = 7;
  localparam int unsigned MaxYDef = 7;
  localparam int unsigned Cells   = 64;
  localparam int unsigned EpochW  = 7;

  localparam logic [1:0] DIR_XM = 2'd0;
  localparam logic [1:0] DIR_XP = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YM = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_INIT, ST_SCAN, ST_DECIDE, ST_EXP_RD, ST_EXP_EV,
    ST_COMMIT, ST_CLOSE, ST_TR_WR, ST_TR_WT, ST_EM_RD, ST_EM_LD, ST_NF
  } st_e;

  typedef enum logic [1:0] {ACT_NONE, ACT_UPD, ACT_INS} act_e;

  typedef struct packed {
    logic [2:0] start_x;
    logic [2:0] start_y;
    logic [2:0] end_x;
    logic [2:0] end_y;
  } czar_in_t;

  typedef struct packed {
    logic [2:0] step_x;
    logic [2:0] step_y;
    logic [9:0] path_cost;
    logic       found;
    logic       last_step;
  } czar_out_t;

  typedef struct packed {
    logic        open;
    logic        closed;
    logic [1:0]  dir;
    logic [9:0]  g;
    logic [10:0] f;
    logic [9:0]  stamp;
  } cell_ent_t;

  typedef struct packed {
    act_e        act;
    logic [5:0]  n;
    logic [9:0]  g;
    logic [10:0] f;
    logic [20:0] old_key;
  } nb_rec_t;

  function automatic logic [2:0] zone_of(logic [2:0] x, logic [2:0] y);
    logic [2:0] z;
    case (y[1:0])
      2'd1:    z = 3'd1 + {1'b0, x[1:0] + 2'd1};
      2'd3:    z = 3'd1 + {1'b0, x[1:0] + 2'd3};
      2'd0:    z = 3'd4 - {1'b0, x[1:0] + 2'd3};
      default: z = 3'd4 - {1'b0, x[1:0] + 2'd1};
    endcase
    return z;
  endfunction

  function automatic logic move_blocked(logic [2:0] zs, logic [2:0] zd);
    logic b;
    if (zs == 3'd1 && zd == 3'd4) b = 1'b0;
    else if (zs == 3'd4 && zd == 3'd1) b = 1'b1;
    else b = (zs < zd);
    return b;
  endfunction

  // Step back from a cell along the move that reached it.
  function automatic logic [5:0] parent_of(logic [5:0] c, logic [1:0] dir);
    logic [5:0] p;
    case (dir)
      DIR_XM:  p = c + 6'd1;
      DIR_XP:  p = c - 6'd1;
      DIR_YP:  p = c - 6'd8;
      default: p = c + 6'd8;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/czar_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module czar_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/clock_zone_grid_astar_router.sv
// Top level of the clock zone constrained A* grid router
`default_nettype none
`include "assert_macros.svh"
// One item is a query (start cell, end cell) on an 8 by 8 grid. The block
// answers with the route cells, start first, each carrying the route cost,
// last_step on the final one, or with a single not-found item. All cell state
// (open/closed flags, parent move, g, f, ordering stamp) lives in one cell RAM
// with a registered read. A query starts with a clearing pass over all 64
// cells, then per expanded cell a scan of the cell RAM for the best open cell
// followed by decision, neighbor reads, write-back and close; once the end
// cell is chosen the route is traced back from it through the parent moves and
// its cells are emitted one by one. Ties in f resolve by insertion order
// through a per-cell stamp. Queries are taken one at a time; the input stalls
// until the previous query has handed its last item to the output register.
// step_cost may be written at any idle time.
module clock_zone_grid_astar_router
  import czar_pkg::*;
#(
  parameter int unsigned MAX_X = MaxXDef,
  parameter int unsigned MAX_Y = MaxYDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire czar_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output czar_out_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [3:0] cfg_data_i
);

  localparam int unsigned EntW = $bits(cell_ent_t);

  st_e         state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [1:0]  d_q, d_d;
  logic        have_q, have_d;
  logic        pend_q, pend_d;
  logic [5:0]  pidx_q, pidx_d;
  logic [EpochW-1:0] epoch_q, epoch_d;
  logic [6:0]  len_q, len_d;
  logic [6:0]  i_q, i_d;
  logic [3:0]  step_cost_q;
  logic        out_valid_q;
  czar_out_t   out_q, out_d;
  logic        out_load;

  czar_in_t    qry_q, qry_d;
  logic [5:0]  best_idx_q, best_idx_d;
  cell_ent_t   best_ent_q, best_ent_d;
  logic [5:0]  c_q, c_d;
  nb_rec_t     rec_q [4];
  nb_rec_t     rec_new;
  logic        rec_we;

  // cell RAM port
  logic            cell_we, cell_re;
  logic [5:0]      cell_waddr, cell_raddr;
  cell_ent_t       cell_wdata, cell_rd;
  logic [EntW-1:0] cell_rdata;

  // route RAM port
  logic       rt_we, rt_re;
  logic [5:0] rt_waddr, rt_raddr, rt_rdata;

  czar_ram #(.Width(EntW), .Depth(Cells)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cell_re),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  czar_ram #(.Width(6), .Depth(Cells)) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (rt_waddr),
    .wdata_i (c_q),
    .re_i    (rt_re),
    .raddr_i (rt_raddr),
    .rdata_o (rt_rdata)
  );

  assign cell_rd     = cell_ent_t'(cell_rdata);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Output register may take a new item when empty or being drained.
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Neighbor of the current cell in direction d_q.
  logic [2:0]  cx, cy, nx, ny, dx, dy;
  logic        nb_ok;
  logic [5:0]  nb_n;
  logic [9:0]  ng;
  logic [3:0]  hsum;
  logic [7:0]  h;
  logic [10:0] nf;

  assign cx = best_idx_q[2:0];
  assign cy = best_idx_q[5:3];

  always_comb begin
    nx = cx;
    ny = cy;
    case (d_q)
      DIR_XM: begin
        nb_ok = (cx != 3'd0);
        nx    = cx - 3'd1;
      end
      DIR_XP: begin
        nb_ok = (cx < 3'(MAX_X));
        nx    = cx + 3'd1;
      end
      DIR_YP: begin
        nb_ok = (cy < 3'(MAX_Y));
        ny    = cy + 3'd1;
      end
      default: begin
        nb_ok = (cy != 3'd0);
        ny    = cy - 3'd1;
      end
    endcase
    nb_ok = nb_ok && !move_blocked(zone_of(cx, cy), zone_of(nx, ny));
  end

  assign nb_n = {ny, nx};
  assign dx   = (nx > qry_q.end_x) ? nx - qry_q.end_x : qry_q.end_x - nx;
  assign dy   = (ny > qry_q.end_y) ? ny - qry_q.end_y : qry_q.end_y - ny;
  assign hsum = {1'b0, dx} + {1'b0, dy};
  assign h    = {4'b0, hsum} * {4'b0, step_cost_q};
  assign ng   = best_ent_q.g + {6'b0, step_cost_q};
  assign nf   = {1'b0, ng} + {3'b0, h};

  // Ordering stamp sub-field: updated cells keep their old relative order,
  // inserted cells follow in direction order.
  logic [2:0] upd_rank, ins_rank, sub;
  always_comb begin
    upd_rank = '0;
    ins_rank = '0;
    for (int j = 0; j < 4; j++) begin
      if (rec_q[j].act == ACT_UPD && 2'(j) != d_q &&
          rec_q[j].old_key < rec_q[d_q].old_key) begin
        upd_rank = upd_rank + 3'd1;
      end
      if (rec_q[j].act == ACT_INS && 2'(j) < d_q) begin
        ins_rank = ins_rank + 3'd1;
      end
    end
    sub = (rec_q[d_q].act == ACT_UPD) ? upd_rank : 3'd4 + ins_rank;
  end

  logic scan_better;
  assign scan_better = cell_rd.open &&
      (!have_q || cell_rd.f < best_ent_q.f ||
       (cell_rd.f == best_ent_q.f && cell_rd.stamp < best_ent_q.stamp));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    d_d        = d_q;
    have_d     = have_q;
    pend_d     = 1'b0;
    pidx_d     = cnt_q[5:0];
    epoch_d    = epoch_q;
    len_d      = len_q;
    i_d        = i_q;
    qry_d      = qry_q;
    best_idx_d = best_idx_q;
    best_ent_d = best_ent_q;
    c_d        = c_q;
    out_d      = out_q;
    out_load   = 1'b0;
    rec_we     = 1'b0;
    rec_new    = '{act: ACT_NONE, n: nb_n, g: ng, f: nf, old_key: {cell_rd.f, cell_rd.stamp}};
    cell_we    = 1'b0;
    cell_re    = 1'b0;
    cell_waddr = cnt_q[5:0];
    cell_raddr = cnt_q[5:0];
    cell_wdata = '0;
    rt_we      = 1'b0;
    rt_re      = 1'b0;
    rt_waddr   = len_q[5:0];
    rt_raddr   = 6'(i_q - 7'd1);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          qry_d = in_data_i;
          cnt_d = '0;
          if (in_data_i.start_x > 3'(MAX_X) || in_data_i.end_x > 3'(MAX_X) ||
              in_data_i.start_y > 3'(MAX_Y) || in_data_i.end_y > 3'(MAX_Y)) begin
            state_d = ST_NF;
          end else begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cell_we = 1'b1;
        cnt_d   = cnt_q + 7'd1;
        if (cnt_q[5:0] == 6'd63) state_d = ST_INIT;
      end
      ST_INIT: begin
        cell_we          = 1'b1;
        cell_waddr       = {qry_q.start_y, qry_q.start_x};
        cell_wdata.open  = 1'b1;
        epoch_d          = EpochW'(1);
        cnt_d            = '0;
        have_d           = 1'b0;
        state_d          = ST_SCAN;
      end
      ST_SCAN: begin
        if (!cnt_q[6]) begin
          cell_re = 1'b1;
          pend_d  = 1'b1;
          cnt_d   = cnt_q + 7'd1;
        end
        if (pend_q && scan_better) begin
          have_d     = 1'b1;
          best_idx_d = pidx_q;
          best_ent_d = cell_rd;
        end
        if (cnt_q[6] && !pend_q) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        d_d = DIR_XM;
        if (!have_q) begin
          state_d = ST_NF;
        end else if (best_idx_q == {qry_q.end_y, qry_q.end_x}) begin
          c_d     = best_idx_q;
          len_d   = '0;
          state_d = ST_TR_WR;
        end else begin
          state_d = ST_EXP_RD;
        end
      end
      ST_EXP_RD: begin
        if (nb_ok) begin
          cell_re    = 1'b1;
          cell_raddr = nb_n;
          state_d    = ST_EXP_EV;
        end else begin
          rec_we = 1'b1;
          d_d    = d_q + 2'd1;
          if (d_q == DIR_YM) state_d = ST_COMMIT;
        end
      end
      ST_EXP_EV: begin
        rec_we = 1'b1;
        if (cell_rd.closed) rec_new.act = ACT_NONE;
        else if (cell_rd.open) rec_new.act = (cell_rd.g > ng) ? ACT_UPD : ACT_NONE;
        else rec_new.act = ACT_INS;
        d_d = d_q + 2'd1;
        state_d = (d_q == DIR_YM) ? ST_COMMIT : ST_EXP_RD;
      end
      ST_COMMIT: begin
        cell_we          = (rec_q[d_q].act != ACT_NONE);
        cell_waddr       = rec_q[d_q].n;
        cell_wdata.open  = 1'b1;
        cell_wdata.dir   = d_q;
        cell_wdata.g     = rec_q[d_q].g;
        cell_wdata.f     = rec_q[d_q].f;
        cell_wdata.stamp = {epoch_q, sub};
        d_d = d_q + 2'd1;
        if (d_q == DIR_YM) state_d = ST_CLOSE;
      end
      ST_CLOSE: begin
        cell_we           = 1'b1;
        cell_waddr        = best_idx_q;
        cell_wdata        = best_ent_q;
        cell_wdata.open   = 1'b0;
        cell_wdata.closed = 1'b1;
        epoch_d           = epoch_q + EpochW'(1);
        cnt_d             = '0;
        have_d            = 1'b0;
        state_d           = ST_SCAN;
      end
      ST_TR_WR: begin
        // Record the cell, stop at the start or after 64 cells, else fetch its parent move.
        rt_we = 1'b1;
        len_d = len_q + 7'd1;
        if (c_q == {qry_q.start_y, qry_q.start_x} || len_q == 7'd63) begin
          i_d     = len_q + 7'd1;
          state_d = ST_EM_RD;
        end else begin
          cell_re    = 1'b1;
          cell_raddr = c_q;
          state_d    = ST_TR_WT;
        end
      end
      ST_TR_WT: begin
        c_d     = parent_of(c_q, cell_rd.dir);
        state_d = ST_TR_WR;
      end
      ST_EM_RD: begin
        rt_re   = 1'b1;
        state_d = ST_EM_LD;
      end
      ST_EM_LD: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_d.step_x    = rt_rdata[2:0];
          out_d.step_y    = rt_rdata[5:3];
          out_d.path_cost = best_ent_q.g;
          out_d.found     = 1'b1;
          out_d.last_step = (i_q == 7'd1);
          i_d             = i_q - 7'd1;
          state_d         = (i_q == 7'd1) ? ST_IDLE : ST_EM_RD;
        end
      end
      ST_NF: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_d           = '0;
          out_d.last_step = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      d_q         <= DIR_XM;
      have_q      <= 1'b0;
      pend_q      <= 1'b0;
      epoch_q     <= '0;
      len_q       <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
      step_cost_q <= 4'd1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      d_q     <= d_d;
      have_q  <= have_d;
      pend_q  <= pend_d;
      epoch_q <= epoch_d;
      len_q   <= len_d;
      i_q     <= i_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) step_cost_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q      <= qry_d;
    best_idx_q <= best_idx_d;
    best_ent_q <= best_ent_d;
    c_q        <= c_d;
    pidx_q     <= pidx_d;
    out_q      <= out_d;
    if (rec_we) rec_q[d_q] <= rec_new;
  end

  // Read and write of the cell RAM never fall in the same cycle.
  `ASSERT_IMPL(a_no_rw_overlap, cell_we, !cell_re)
  // A not-found item is always the last one, with zero payload.
  `ASSERT_IMPL(a_nf_last, out_valid_o && !out_data_o.found,
               out_data_o.last_step && out_data_o.path_cost == 10'd0)
  // An accepted query leaves the idle state in the next cycle.
  `ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o, in_stall_o)

endmodule
`default_nettype wire
